### rtl/l2u_pkg.sv
// ----------------------------------------------------------------------------
// l2u_pkg
// shared types and constants for the latin-2 to utf-8 converter
// ----------------------------------------------------------------------------
package l2u_pkg;

  localparam int unsigned RomDepth = 96;

  // first byte value served by the code point rom
  localparam logic [7:0] HIGH_BASE = 8'hA0;

  // utf-8 lead and continuation marks
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] CONT  = 8'h80;
  localparam logic [5:0] CONT_MASK = 6'h3F;

  // encoded length codes
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // windows-1250 punctuation bytes and their code points
  localparam logic [7:0] B_LOW_DQUOTE = 8'h84;
  localparam logic [7:0] B_ELLIPSIS   = 8'h85;
  localparam logic [7:0] B_LSQUOTE    = 8'h91;
  localparam logic [7:0] B_RSQUOTE    = 8'h92;
  localparam logic [7:0] B_LDQUOTE    = 8'h93;
  localparam logic [7:0] B_RDQUOTE    = 8'h94;
  localparam logic [7:0] B_EN_DASH    = 8'h96;
  localparam logic [7:0] B_EM_DASH    = 8'h97;

  localparam logic [15:0] CP_LOW_DQUOTE = 16'h201E;
  localparam logic [15:0] CP_ELLIPSIS   = 16'h2026;
  localparam logic [15:0] CP_LSQUOTE    = 16'h2018;
  localparam logic [15:0] CP_RSQUOTE    = 16'h2019;
  localparam logic [15:0] CP_LDQUOTE    = 16'h201C;
  localparam logic [15:0] CP_RDQUOTE    = 16'h201D;
  localparam logic [15:0] CP_EN_DASH    = 16'h2013;
  localparam logic [15:0] CP_EM_DASH    = 16'h2014;

  // code points for bytes 0xa0..0xff
  localparam logic [15:0] HIGH_ROM [RomDepth] = '{
    16'h00A0,16'h0104,16'h02D8,16'h0141,16'h00A4,16'h013D,16'h015A,16'h00A7,
    16'h00A8,16'h0160,16'h015E,16'h0164,16'h0179,16'h00AD,16'h017D,16'h017B,
    16'h00B0,16'h0105,16'h02DB,16'h0142,16'h00B4,16'h013E,16'h015B,16'h02C7,
    16'h00B8,16'h0161,16'h015F,16'h0165,16'h017A,16'h02DD,16'h017E,16'h017C,
    16'h0154,16'h00C1,16'h00C2,16'h0102,16'h00C4,16'h0139,16'h0106,16'h00C7,
    16'h010C,16'h00C9,16'h0118,16'h00CB,16'h011A,16'h00CD,16'h00CE,16'h010E,
    16'h0110,16'h0143,16'h0147,16'h00D3,16'h00D4,16'h0150,16'h00D6,16'h00D7,
    16'h0158,16'h016E,16'h00DA,16'h0170,16'h00DC,16'h00DD,16'h0162,16'h00DF,
    16'h0155,16'h00E1,16'h00E2,16'h0103,16'h00E4,16'h013A,16'h0107,16'h00E7,
    16'h010D,16'h00E9,16'h0119,16'h00EB,16'h011B,16'h00ED,16'h00EE,16'h010F,
    16'h0111,16'h0144,16'h0148,16'h00F3,16'h00F4,16'h0151,16'h00F6,16'h00F7,
    16'h0159,16'h016F,16'h00FA,16'h0171,16'h00FC,16'h00FD,16'h0163,16'h02D9
  };

  // one encoded input byte: up to three utf-8 bytes, first in b0
  typedef struct packed {
    logic       valid;
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } enc_t;

endpackage

### rtl/l2u_encode.sv
// ----------------------------------------------------------------------------
// l2u_encode
// maps one latin-2 byte to its code point and encodes it as utf-8
// ----------------------------------------------------------------------------
module l2u_encode (
  input  logic [7:0]    in_byte,
  output l2u_pkg::enc_t enc
);

  logic [15:0] cp;
  logic        mapped;
  logic [7:0]  rom_off;

  assign rom_off = in_byte - l2u_pkg::HIGH_BASE;

  always_comb begin
    cp     = 16'h0000;
    mapped = 1'b1;
    if (!in_byte[7]) begin
      cp = {8'h00, in_byte};
    end else if (in_byte >= l2u_pkg::HIGH_BASE) begin
      cp = l2u_pkg::HIGH_ROM[rom_off[6:0]];
    end else begin
      case (in_byte)
        l2u_pkg::B_LOW_DQUOTE: cp = l2u_pkg::CP_LOW_DQUOTE;
        l2u_pkg::B_ELLIPSIS:   cp = l2u_pkg::CP_ELLIPSIS;
        l2u_pkg::B_LSQUOTE:    cp = l2u_pkg::CP_LSQUOTE;
        l2u_pkg::B_RSQUOTE:    cp = l2u_pkg::CP_RSQUOTE;
        l2u_pkg::B_LDQUOTE:    cp = l2u_pkg::CP_LDQUOTE;
        l2u_pkg::B_RDQUOTE:    cp = l2u_pkg::CP_RDQUOTE;
        l2u_pkg::B_EN_DASH:    cp = l2u_pkg::CP_EN_DASH;
        l2u_pkg::B_EM_DASH:    cp = l2u_pkg::CP_EM_DASH;
        default:               mapped = 1'b0;
      endcase
    end
  end

  // length by code point range, bytes left aligned in b0
  always_comb begin
    enc.valid = mapped;
    if (cp[15:7] == 9'd0) begin
      enc.len = l2u_pkg::LEN_ONE;
      enc.b0  = cp[7:0];
      enc.b1  = 8'h00;
      enc.b2  = 8'h00;
    end else if (cp[15:11] == 5'd0) begin
      enc.len = l2u_pkg::LEN_TWO;
      enc.b0  = l2u_pkg::LEAD2 | {3'b000, cp[10:6]};
      enc.b1  = l2u_pkg::CONT | {2'b00, cp[5:0] & l2u_pkg::CONT_MASK};
      enc.b2  = 8'h00;
    end else begin
      enc.len = l2u_pkg::LEN_THREE;
      enc.b0  = l2u_pkg::LEAD3 | {4'h0, cp[15:12]};
      enc.b1  = l2u_pkg::CONT | {2'b00, cp[11:6]};
      enc.b2  = l2u_pkg::CONT | {2'b00, cp[5:0] & l2u_pkg::CONT_MASK};
    end
  end

endmodule

### rtl/latin2_to_utf8_converter.sv
// ----------------------------------------------------------------------------
// latin2_to_utf8_converter
// streaming iso-8859-2 to utf-8 transcoder, one byte in, up to three out
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid / in_ready / in_byte carries one latin-2 byte per
//   item; output channel out_valid / out_ready / out_byte / last_of_run
//   carries one utf-8 byte per item, last_of_run set on the final byte of
//   the run that belongs to one input byte
//   ascii bytes give one output byte, 0xa0..0xff give two, the eight
//   windows-1250 punctuation bytes give three; any other byte in
//   0x80..0x9f is consumed and gives nothing
//   path: an accepted byte passes the input register, then the result
//   register behind the encoder, before its first output byte appears
//   throughput: one input byte per cycle while every run is one byte long
//   and out_ready stays high; a multi-byte run holds the result register
//   until its final byte is taken, so the output port sets the pace there
//   stall: when out_ready is low the result register holds its byte; the
//   input register takes items until it holds a mapped byte, then in_ready drops
//   reset: rst (synchronous, active high) empties both registers; the block
//   keeps no other state
// ----------------------------------------------------------------------------
module latin2_to_utf8_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;

  // result register: bytes still to send, shifted toward b0
  logic       res_valid;
  logic [1:0] res_left;
  logic [7:0] res_b0;
  logic [7:0] res_b1;
  logic [7:0] res_b2;

  l2u_pkg::enc_t enc;

  logic res_done;    // final byte of the run leaves this cycle
  logic res_free;    // result register can take a new run
  logic hold_move;   // input register item leaves (encoded or dropped)
  logic res_load;

  l2u_encode u_enc (
    .in_byte (hold_byte),
    .enc     (enc)
  );

  assign res_done  = res_valid && out_ready && (res_left == l2u_pkg::LEN_ONE);
  assign res_free  = !res_valid || res_done;
  // an unmapped byte leaves without needing the result register
  assign hold_move = hold_valid && (!enc.valid || res_free);
  assign res_load  = hold_valid && enc.valid && res_free;
  assign in_ready  = !hold_valid || hold_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_left  <= 2'd0;
    end else if (res_load) begin
      res_valid <= 1'b1;
      res_left  <= enc.len;
    end else if (res_done) begin
      res_valid <= 1'b0;
    end else if (res_valid && out_ready) begin
      res_left <= res_left - 2'd1;
    end
  end

  // payload: load a new run or shift the next byte into place
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_b0 <= enc.b0;
      res_b1 <= enc.b1;
      res_b2 <= enc.b2;
    end else if (res_valid && out_ready) begin
      res_b0 <= res_b1;
      res_b1 <= res_b2;
    end
  end

  assign out_valid   = res_valid;
  assign out_byte    = res_b0;
  assign last_of_run = (res_left == l2u_pkg::LEN_ONE);

endmodule

### rtl/l2u_checker.sv
// ----------------------------------------------------------------------------
// l2u_checker
// port level checks for the latin-2 to utf-8 converter
// ----------------------------------------------------------------------------
module l2u_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // nothing shows right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // with no result pending the input side never backs up
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  // a held output item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output item changed while stalled");

  // a waiting input item stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte))
    else $error("input item changed while waiting");

  // a non-final byte of a run is a lead or continuation byte, never ascii
  a_multi_byte_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> out_byte[7])
    else $error("non-final byte of a run is an ascii byte");

endmodule

bind latin2_to_utf8_converter l2u_checker u_l2u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_byte     (in_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
